// File: src/tsfp_pkg.sv
`timescale 1ns / 1ps

package tsfp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned RsW       = 2 * HalfW;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned PayloadW  = TimeW + HalfW + HalfW + StatusW;
  localparam int unsigned TdataW    = ((PayloadW + 7) / 8) * 8;

  localparam logic [IdxW-1:0] AvgBytes   = IdxW'(2);
  localparam logic [IdxW-1:0] TimeBytes  = IdxW'(8);
  localparam logic [IdxW-1:0] RecBytes   = IdxW'(12);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAG_MODE     = 3'd0,
    CFG_TAG_MOOD     = 3'd1,
    CFG_TAG_AVERAGE  = 3'd2,
    CFG_TAG_RECORD   = 3'd3,
    CFG_MODE_RESTING = 3'd4,
    CFG_MODE_ACTIVE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_MODE_TAG = 3'd0,
    PH_MODE_VAL = 3'd1,
    PH_MOOD_TAG = 3'd2,
    PH_MOOD_VAL = 3'd3,
    PH_AVG_TAG  = 3'd4,
    PH_AVG_VAL  = 3'd5,
    PH_REC_TAG  = 3'd6,
    PH_REC_VAL  = 3'd7
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK_REST     = 3'd0,
    ST_OK_ACTIVE   = 3'd1,
    ST_BAD_MODE    = 3'd2,
    ST_WRONG_ORDER = 3'd3,
    ST_UNKNOWN_TAG = 3'd4,
    ST_TRUNCATED   = 3'd5
  } status_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] tag_mode;
    logic [ByteW-1:0] tag_mood;
    logic [ByteW-1:0] tag_average;
    logic [ByteW-1:0] tag_record;
    logic [ByteW-1:0] mode_resting;
    logic [ByteW-1:0] mode_active;
  } cfg_t;

  typedef struct packed {
    kind_e             item_kind;
    logic [TimeW-1:0]  time_ms;
    logic [HalfW-1:0]  heart_rate;
    logic [HalfW-1:0]  step_count;
    status_e           frame_status;
  } result_t;

endpackage

// File: src/tsfp_cfg_regs.sv
`timescale 1ns / 1ps

module tsfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsfp_pkg::ByteW-1:0]    cfg_data_i,
  output tsfp_pkg::cfg_t                cfg_o
);
  import tsfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAG_MODE:     cfg_d.tag_mode     = cfg_data_i;
        CFG_TAG_MOOD:     cfg_d.tag_mood     = cfg_data_i;
        CFG_TAG_AVERAGE:  cfg_d.tag_average  = cfg_data_i;
        CFG_TAG_RECORD:   cfg_d.tag_record   = cfg_data_i;
        CFG_MODE_RESTING: cfg_d.mode_resting = cfg_data_i;
        CFG_MODE_ACTIVE:  cfg_d.mode_active  = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_mode     <= ByteW'(0);
      cfg_q.tag_mood     <= ByteW'(1);
      cfg_q.tag_average  <= ByteW'(2);
      cfg_q.tag_record   <= ByteW'(3);
      cfg_q.mode_resting <= ByteW'(0);
      cfg_q.mode_active  <= ByteW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/tsfp_parser.sv
`timescale 1ns / 1ps

module tsfp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsfp_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  input  logic [tsfp_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        in_last_i,
  output logic                        res_valid_o,
  output tsfp_pkg::result_t           res_o
);
  import tsfp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d, idx_inc;
  logic [TimeW-1:0]  shift_q, shift_d;
  logic [RsW-1:0]    rs_q, rs_d;
  logic [ByteW-1:0]  mode_q, mode_d;
  status_e           err_code_q, err_code_d;
  logic              err_seen_q, err_seen_d;
  logic [ByteW-1:0]  expected;
  logic              tag_any;
  logic              tag_hit;
  logic              new_err;
  status_e           new_err_code;
  logic              emit_rec;
  logic              final_ok;

  assign idx_inc = idx_q + IdxW'(1);

  assign tag_any = (in_byte_i == cfg_i.tag_mode) || (in_byte_i == cfg_i.tag_mood) ||
                   (in_byte_i == cfg_i.tag_average) || (in_byte_i == cfg_i.tag_record);

  always_comb begin
    case (phase_q)
      PH_MODE_TAG: expected = cfg_i.tag_mode;
      PH_MOOD_TAG: expected = cfg_i.tag_mood;
      PH_AVG_TAG:  expected = cfg_i.tag_average;
      default:     expected = cfg_i.tag_record;
    endcase
  end

  assign tag_hit      = (in_byte_i == expected);
  assign new_err      = !err_seen_q && !tag_hit &&
                        (phase_q inside {PH_MODE_TAG, PH_MOOD_TAG, PH_AVG_TAG, PH_REC_TAG});
  assign new_err_code = tag_any ? ST_WRONG_ORDER : ST_UNKNOWN_TAG;
  assign final_ok     = !err_seen_q && (phase_q == PH_REC_TAG) && tag_hit && in_last_i;
  assign emit_rec     = !err_seen_q && (phase_q == PH_REC_VAL) && (idx_inc >= RecBytes);

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    shift_d    = shift_q;
    rs_d       = rs_q;
    mode_d     = mode_q;
    err_code_d = err_code_q;
    err_seen_d = err_seen_q;

    if (!err_seen_q) begin
      case (phase_q)
        PH_MODE_TAG, PH_MOOD_TAG, PH_AVG_TAG, PH_REC_TAG: begin
          if (tag_hit) begin
            if (phase_q != PH_REC_TAG || !in_last_i) begin
              phase_d = phase_e'(phase_q + 3'd1);
              idx_d   = '0;
            end
          end else if (tag_any) begin
            err_code_d = ST_WRONG_ORDER;
            err_seen_d = 1'b1;
          end else begin
            err_code_d = ST_UNKNOWN_TAG;
            err_seen_d = 1'b1;
          end
        end
        PH_MODE_VAL: begin
          mode_d  = in_byte_i;
          phase_d = PH_MOOD_TAG;
        end
        PH_MOOD_VAL: begin
          phase_d = PH_AVG_TAG;
        end
        PH_AVG_VAL: begin
          idx_d = idx_inc;
          if (idx_inc >= AvgBytes) begin
            phase_d = PH_REC_TAG;
            idx_d   = '0;
          end
        end
        PH_REC_VAL: begin
          if (idx_q < TimeBytes) begin
            shift_d = {shift_q[TimeW-ByteW-1:0], in_byte_i};
          end else begin
            rs_d = {rs_q[RsW-ByteW-1:0], in_byte_i};
          end
          idx_d = idx_inc;
          if (idx_inc >= RecBytes) begin
            phase_d  = PH_REC_TAG;
            idx_d    = '0;
          end
        end
        default: phase_d = phase_q;
      endcase
    end

    if (in_last_i) begin
      phase_d    = PH_MODE_TAG;
      idx_d      = '0;
      shift_d    = '0;
      rs_d       = '0;
      mode_d     = '0;
      err_code_d = ST_OK_REST;
      err_seen_d = 1'b0;
    end
  end

  always_comb begin
    res_o = '0;
    if (in_last_i) begin
      res_o.item_kind = KIND_STATUS;
      if (err_seen_q) begin
        res_o.frame_status = err_code_q;
      end else if (new_err) begin
        res_o.frame_status = new_err_code;
      end else if (!final_ok) begin
        res_o.frame_status = ST_TRUNCATED;
      end else if (mode_q == cfg_i.mode_resting) begin
        res_o.frame_status = ST_OK_REST;
      end else if (mode_q == cfg_i.mode_active) begin
        res_o.frame_status = ST_OK_ACTIVE;
      end else begin
        res_o.frame_status = ST_BAD_MODE;
      end
    end else if (emit_rec) begin
      res_o.item_kind  = KIND_RECORD;
      res_o.time_ms    = shift_d;
      res_o.heart_rate = rs_d[RsW-1:HalfW];
      res_o.step_count = rs_d[HalfW-1:0];
    end
  end

  assign res_valid_o = in_valid_i && (in_last_i || emit_rec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MODE_TAG;
      idx_q      <= '0;
      shift_q    <= '0;
      rs_q       <= '0;
      mode_q     <= '0;
      err_code_q <= ST_OK_REST;
      err_seen_q <= 1'b0;
    end else if (in_valid_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      rs_q       <= rs_d;
      mode_q     <= mode_d;
      err_code_q <= err_code_d;
      err_seen_q <= err_seen_d;
    end
  end

endmodule

// File: src/tsfp_out_buf.sv
`timescale 1ns / 1ps

module tsfp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tsfp_pkg::result_t  in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tsfp_pkg::result_t  out_data_o,
  input  logic               out_ready_i
);
  import tsfp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || in_valid_i;
      out_d        = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/tagged_sensor_frame_parser_top.sv
`timescale 1ns / 1ps

// Tagged sensor packet parser. Takes one packet byte per transaction on the slave
// stream (tlast on the final byte) and accepts a byte every cycle while tready is
// high. Each byte goes through a single parser state update; a finished 12-byte
// record is registered in the output buffer before it is sent on the master stream,
// and the last byte of a packet sends a status item instead (tuser high). A two-entry
// output buffer lets the input keep running while the master side stalls for one
// transaction; the input stalls only once both entries hold results. Configure the
// tag and mode registers only while no packet is in flight.

module tagged_sensor_frame_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsfp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tsfp_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // data_byte[7:0]
  input  logic [tsfp_pkg::ByteW-1:0]   s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // time_ms[63:0], heart_rate[79:64], step_count[95:80], frame_status[98:96], zero pad
  output logic [tsfp_pkg::TdataW-1:0]  m_axis_tdata_o,
  // item_kind[0]
  output logic                         m_axis_tuser_o
);
  import tsfp_pkg::*;

  cfg_t    cfg;
  logic    in_acc;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  tsfp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_acc),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsfp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {(TdataW - PayloadW)'(0), out_res.frame_status,
                           out_res.step_count, out_res.heart_rate, out_res.time_ms};
  assign m_axis_tuser_o = out_res.item_kind;

endmodule
